### design/mbbg_pkg.sv
// mbbg_pkg: shared types, register map and bar helpers for the metronome
// beat and bar generator. No dependencies.

package mbbg_pkg;

  localparam int MAX_BARS   = 8;
  localparam int TIME_W     = 48;
  localparam int PERIOD_W   = 32;
  localparam int BEAT_W     = 8;
  localparam int BAR_W      = 3;
  localparam int AMP_W      = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_PERIOD    = 3'd0;
  localparam reg_idx_t REG_BEATS     = 3'd1;
  localparam reg_idx_t REG_BAR_COUNT = 3'd2;
  localparam reg_idx_t REG_SYNC      = 3'd3;
  localparam reg_idx_t REG_AMP_FIRST = 3'd4;
  localparam reg_idx_t REG_AMP_OTHER = 3'd5;
  localparam reg_idx_t REG_BYPASS    = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  // beats of a bar from the packed table, one byte per bar
  function automatic logic [BEAT_W-1:0] bar_beats(input logic [63:0] table_bits,
                                                  input logic [BAR_W-1:0] bar);
    bar_beats = table_bits[{bar, 3'b000} +: BEAT_W];
  endfunction

  // advance the bar position, wrapping at the clamped bar count
  function automatic logic [BAR_W-1:0] next_bar(input logic [BAR_W-1:0] bar,
                                                input logic [3:0] count);
    logic [3:0]       n;
    logic [BAR_W-1:0] p;
    n = count;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(MAX_BARS)) n = 4'(MAX_BARS);
    p = bar + 3'd1;
    if ({1'b0, p} >= n) p = '0;
    next_bar = p;
  endfunction

endpackage

### design/metronome_beat_bar_generator.sv
// metronome_beat_bar_generator: click amplitude and beat/bar position per
// audio sample tick, with a bit-serial divider for sync mode.
// Depends on mbbg_pkg.
//
//  port group   dir  role
//  s_*          in   sample tick item: object_time, rolling
//  m_*          out  click item: amplitude, on_beat, downbeat, beat, bar
//  p*           in   register access, 64-bit data, register i at 8*i
//
// free-run items take an update step in ST_IDLE and a result step in ST_FIN.
// sync items take an accept step, the restoring divider steps in ST_DIV
// (one quotient bit a cycle, folded into the modulo-beats remainder
// as it appears) and a result step in ST_FIN.
// rst is synchronous; registers return to their reset values, position is 0.
// a held result stalls only the result cycle; the next item is taken after.

module metronome_beat_bar_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // [47:0] object_time, [48] rolling, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] click_amplitude, [16] on_beat,
                                 // [17] downbeat, [25:18] beat_index,
                                 // [28:26] bar_index, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [mbbg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mbbg_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mbbg_pkg::CFG_DATA_W-1:0] prdata,
  output logic        pready
);
  import mbbg_pkg::*;

  localparam int DIV_STEPS = TIME_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // configuration registers
  logic [PERIOD_W-1:0] period_samples;
  logic [63:0]         beats_table;
  logic [3:0]          bar_count;
  logic                sync_mode;
  logic [AMP_W-1:0]    amp_first;
  logic [AMP_W-1:0]    amp_other;
  logic                bypass_on;

  // position state
  logic [PERIOD_W-1:0] sample_in_beat;
  logic [BEAT_W-1:0]   beat_count;
  logic [BAR_W-1:0]    bar_pos;

  state_t state;
  logic   rolling;

  // divider
  logic [TIME_W-1:0]   dvd;
  logic [PERIOD_W-1:0] rem;
  logic [BEAT_W-1:0]   macc;
  logic [CNT_W-1:0]    cnt;

  logic [PERIOD_W-1:0] period_eff;
  logic [BEAT_W-1:0]   nb;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic                s_acc;
  logic                out_load;

  logic [PERIOD_W:0]   trial;
  logic                qbit;
  logic [PERIOD_W-1:0] rem_next;
  logic [BEAT_W:0]     mtrial;
  logic [BEAT_W-1:0]   macc_next;
  logic [BEAT_W-1:0]   beat_inc;

  logic                beat_now;
  logic [AMP_W-1:0]    amp;

  assign pready     = 1'b1;
  assign cfg_idx    = paddr[CFG_ADDR_W-1:3];
  assign cfg_wr     = psel & penable & pwrite & pready;
  assign period_eff = (period_samples == '0) ? PERIOD_W'(1) : period_samples;
  assign nb         = bar_beats(beats_table, bar_pos);

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid & s_tready;
  assign out_load = (state == ST_FIN) & (~m_tvalid | m_tready);

  // one restoring step; the quotient bit also feeds the modulo-beats remainder
  assign trial     = {rem, dvd[TIME_W-1]};
  assign qbit      = trial >= {1'b0, period_eff};
  assign rem_next  = qbit ? PERIOD_W'(trial - {1'b0, period_eff}) : trial[PERIOD_W-1:0];
  assign mtrial    = {macc, qbit};
  assign macc_next = (mtrial >= {1'b0, nb}) ? BEAT_W'(mtrial - {1'b0, nb})
                                            : mtrial[BEAT_W-1:0];
  assign beat_inc  = beat_count + BEAT_W'(1);

  assign beat_now = (sample_in_beat == '0) & ~(sync_mode & ~rolling);
  assign amp      = (beat_now & ~bypass_on)
                    ? ((beat_count != '0) ? amp_other : amp_first) : '0;

  always_comb begin
    case (cfg_idx)
      REG_PERIOD:    prdata = CFG_DATA_W'(period_samples);
      REG_BEATS:     prdata = beats_table;
      REG_BAR_COUNT: prdata = CFG_DATA_W'(bar_count);
      REG_SYNC:      prdata = CFG_DATA_W'(sync_mode);
      REG_AMP_FIRST: prdata = CFG_DATA_W'(amp_first);
      REG_AMP_OTHER: prdata = CFG_DATA_W'(amp_other);
      REG_BYPASS:    prdata = CFG_DATA_W'(bypass_on);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_samples <= PERIOD_W'(24000);
      beats_table    <= 64'd4;
      bar_count      <= 4'd1;
      sync_mode      <= 1'b0;
      amp_first      <= AMP_W'(131);
      amp_other      <= AMP_W'(66);
      bypass_on      <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PERIOD:    period_samples <= pwdata[PERIOD_W-1:0];
        REG_BEATS:     beats_table    <= pwdata;
        REG_BAR_COUNT: bar_count      <= pwdata[3:0];
        REG_SYNC:      sync_mode      <= pwdata[0];
        REG_AMP_FIRST: amp_first      <= pwdata[AMP_W-1:0];
        REG_AMP_OTHER: amp_other      <= pwdata[AMP_W-1:0];
        REG_BYPASS:    bypass_on      <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      sample_in_beat <= '0;
      beat_count     <= '0;
      bar_pos        <= '0;
      m_tvalid       <= 1'b0;
      cnt            <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            rolling <= s_tdata[TIME_W];
            if (sync_mode) begin
              dvd   <= s_tdata[TIME_W-1:0];
              rem   <= '0;
              macc  <= '0;
              cnt   <= '0;
              state <= ST_DIV;
            end else begin
              if (sample_in_beat >= period_eff) begin
                sample_in_beat <= '0;
                if (beat_inc >= nb) begin
                  beat_count <= '0;
                  bar_pos    <= next_bar(bar_pos, bar_count);
                end else begin
                  beat_count <= beat_inc;
                end
              end
              state <= ST_FIN;
            end
          end
        end
        ST_DIV: begin
          dvd  <= {dvd[TIME_W-2:0], 1'b0};
          rem  <= rem_next;
          macc <= macc_next;
          cnt  <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            sample_in_beat <= rem_next;
            // a bar with no beats moves straight on to the next bar
            if (nb != '0) begin
              beat_count <= macc_next;
            end else begin
              beat_count <= '0;
              bar_pos    <= next_bar(bar_pos, bar_count);
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            m_tdata <= {3'b000, bar_pos, beat_count, (beat_count == '0), beat_now, amp};
            sample_in_beat <= sample_in_beat + PERIOD_W'(1);
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rise_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FIN))
    else $error("result item appeared outside the result cycle");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt != CNT_W'(DIV_STEPS - 1))
      |=> (state == ST_DIV && cnt == $past(cnt) + CNT_W'(1)))
    else $error("divider left early or skipped a step");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && m_tvalid && !m_tready) |=> (state == ST_FIN))
    else $error("result overwritten while output stalled");

endmodule

### tb/tb_metronome_beat_bar_generator.sv
// tb_metronome_beat_bar_generator: drives sample ticks into the metronome block,
// predicts every click item in step with it, and checks each result field by field.
// Depends on mbbg_pkg and metronome_beat_bar_generator.
`timescale 1ns / 100ps

module tb_metronome_beat_bar_generator;
  import mbbg_pkg::*;

  localparam int       LIMIT      = 400000;
  localparam int       LONG_HOLD  = 300;
  localparam int       MAX_PRINT  = 30;
  localparam reg_idx_t REG_UNUSED = 3'd7;

  // packed like the stream buses, lowest field in the lowest bits
  typedef struct packed {
    logic        rolling;
    logic [47:0] object_time;
  } tick_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic [2:0]  bar_idx;
    logic [7:0]  beat_idx;
    logic        downbeat;
    logic        on_beat;
    logic [15:0] amp;
  } click_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // [47:0] object_time, [48] rolling, rest zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [15:0] click_amplitude, [16] on_beat, [17] downbeat,
                               // [25:18] beat_index, [28:26] bar_index, rest zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic        pready;

  metronome_beat_bar_generator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // register copy and position, as the block should hold them
  logic [31:0] cfg_period    = 32'd24000;
  logic [63:0] cfg_beats     = 64'd4;
  logic [3:0]  cfg_bar_count = 4'd1;
  logic        cfg_sync      = 1'b0;
  logic [15:0] cfg_amp_first = 16'd131;
  logic [15:0] cfg_amp_other = 16'd66;
  logic        cfg_bypass    = 1'b0;
  logic [31:0] pos_sample    = '0;
  logic [7:0]  pos_beat      = '0;
  logic [2:0]  pos_bar       = '0;

  tick_t  tick_q[$];
  click_t click_q[$];
  tick_t  cur_tick;
  int     n_errors = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     n_beats = 0;
  int     n_settings = 1;
  int     cycles = 0;
  int     gap_left = 0;
  int     tx_calm = 0;
  int     rx_calm = 0;
  int     stall_left = 0;
  int     hold_left = 0;
  logic   held_once = 1'b0;

  task automatic flag_mismatch(string what, logic [63:0] expv, logic [63:0] gotv);
    if (n_errors < MAX_PRINT)
      $display("[%0t] click %0d: %s expected 0x%0h got 0x%0h", $time, n_checked, what,
               expv, gotv);
    n_errors++;
  endtask

  function automatic logic [7:0] beats_in_bar(logic [2:0] bar);
    return 8'(cfg_beats >> (8 * bar));
  endfunction

  function automatic logic [2:0] bar_after(logic [2:0] bar);
    int lim;
    lim = (cfg_bar_count == 4'd0) ? 1 : (cfg_bar_count > MAX_BARS) ? MAX_BARS : cfg_bar_count;
    return (int'(bar) + 1 >= lim) ? 3'd0 : bar + 3'd1;
  endfunction

  function automatic click_t predict_click(tick_t tk);
    logic [31:0] per;
    logic [63:0] quo;
    logic [7:0]  nb;
    logic        hit;
    click_t      c;
    per = (cfg_period == 32'd0) ? 32'd1 : cfg_period;
    if (cfg_sync) begin
      quo = {16'd0, tk.object_time} / {32'd0, per};
      pos_sample = 32'({16'd0, tk.object_time} % {32'd0, per});
      nb = beats_in_bar(pos_bar);
      if (nb != 8'd0) begin
        pos_beat = 8'(quo % {56'd0, nb});
      end else begin
        pos_beat = '0;
        pos_bar = bar_after(pos_bar);
      end
    end else if (pos_sample >= per) begin
      pos_sample = '0;
      pos_beat = pos_beat + 8'd1;
      if (pos_beat >= beats_in_bar(pos_bar)) begin
        pos_beat = '0;
        pos_bar = bar_after(pos_bar);
      end
    end
    hit = (pos_sample == 32'd0) && !(cfg_sync && !tk.rolling);
    c = '0;
    if (hit && !cfg_bypass) c.amp = (pos_beat != 8'd0) ? cfg_amp_other : cfg_amp_first;
    c.on_beat  = hit;
    c.downbeat = (pos_beat == 8'd0);
    c.beat_idx = pos_beat;
    c.bar_idx  = pos_bar;
    pos_sample = pos_sample + 32'd1;
    return c;
  endfunction

  // mostly short pauses, a few long ones, and now and then a run with none
  function automatic int pick_pause(inout int calm_left);
    int r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = 30;
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic void push_tick(logic rolling, logic [47:0] t);
    tick_q.push_back({rolling, t});
  endfunction

  // sender: one item at a time from tick_q, prediction taken at acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) begin
        click_q.push_back(predict_click(cur_tick));
        n_sent++;
      end
      if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (tick_q.size() != 0) begin
        cur_tick = tick_q.pop_front();
        s_tdata  <= {7'd0, cur_tick};
        s_tvalid <= 1'b1;
        gap_left <= pick_pause(tx_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: checks each click item against the oldest prediction
  always @(posedge clk) begin : rx
    click_t want;
    click_t got;
    int     p;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (click_q.size() == 0) begin
          flag_mismatch("result with nothing expected", '0, 64'(m_tdata));
        end else begin
          want = click_q.pop_front();
          got  = click_t'(m_tdata);
          n_checked++;
          if (want.on_beat) n_beats++;
          if (got.amp !== want.amp)
            flag_mismatch("click_amplitude", 64'(want.amp), 64'(got.amp));
          if (got.on_beat !== want.on_beat)
            flag_mismatch("on_beat", 64'(want.on_beat), 64'(got.on_beat));
          if (got.downbeat !== want.downbeat)
            flag_mismatch("downbeat", 64'(want.downbeat), 64'(got.downbeat));
          if (got.beat_idx !== want.beat_idx)
            flag_mismatch("beat_index", 64'(want.beat_idx), 64'(got.beat_idx));
          if (got.bar_idx !== want.bar_idx)
            flag_mismatch("bar_index", 64'(want.bar_idx), 64'(got.bar_idx));
          if (got.pad !== want.pad) flag_mismatch("unused bits", 64'(want.pad), 64'(got.pad));
        end
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!held_once && n_checked >= 120) begin
        // long hold-off so the block backs up and stalls the sender
        held_once <= 1'b1;
        hold_left <= LONG_HOLD;
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        p = pick_pause(rx_calm);
        m_tready <= (p == 0);
        stall_left <= (p == 0) ? 0 : p - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[%0t] timeout: %0d items sent, %0d results checked, %0d outstanding",
               $time, n_sent, n_checked, click_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PERIOD:    cfg_period    = val[31:0];
      REG_BEATS:     cfg_beats     = val;
      REG_BAR_COUNT: cfg_bar_count = val[3:0];
      REG_SYNC:      cfg_sync      = val[0];
      REG_AMP_FIRST: cfg_amp_first = val[15:0];
      REG_AMP_OTHER: cfg_amp_other = val[15:0];
      REG_BYPASS:    cfg_bypass    = val[0];
      default: ;
    endcase
  endtask

  // polled on the falling edge so the queues are settled
  task automatic wait_drained();
    do @(negedge clk);
    while (tick_q.size() != 0 || s_tvalid || click_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic shuffle_settings();
    logic [63:0] tbl;
    int          b;
    int          r;
    for (b = 0; b < 8; b++) begin
      r = $urandom_range(0, 9);
      tbl[8*b +: 8] = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : (r == 2) ? 8'($urandom) :
                      8'($urandom_range(1, 4));
    end
    r = $urandom_range(0, 9);
    write_reg(REG_PERIOD, (r == 0) ? 64'd0 : (r == 1) ? 64'($urandom) :
                          64'($urandom_range(1, 6)));
    write_reg(REG_BEATS, tbl);
    write_reg(REG_BAR_COUNT, ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 15)) :
                             64'($urandom_range(1, 8)));
    write_reg(REG_SYNC, 64'($urandom_range(0, 1)));
    write_reg(REG_AMP_FIRST, 64'($urandom_range(0, 65535)));
    write_reg(REG_AMP_OTHER, 64'($urandom_range(0, 65535)));
    write_reg(REG_BYPASS, 64'($urandom_range(0, 5) == 0));
    n_settings++;
  endtask

  initial begin
    logic [47:0] t;
    int          ph;
    int          k;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // straight out of reset: first tick is a downbeat
    push_tick(1'b1, 48'd0);
    push_tick(1'b0, 48'hFFFF_FFFF_FFFF);
    wait_drained();

    // zero period clicks every sample; a zero-beat bar; bar count above eight
    write_reg(REG_PERIOD, 64'd0);
    write_reg(REG_BEATS, 64'hFF01_0101_0103_0002);
    write_reg(REG_BAR_COUNT, 64'd15);
    write_reg(REG_AMP_FIRST, 64'hFFFF);
    write_reg(REG_AMP_OTHER, 64'd0);
    write_reg(REG_UNUSED, '1);
    n_settings++;
    for (k = 0; k < 10; k++) push_tick(1'($urandom_range(0, 1)), rand48());
    wait_drained();

    // count of zero with bar_pos left beyond it: next bar change wraps to 0
    write_reg(REG_BAR_COUNT, 64'd0);
    write_reg(REG_PERIOD, 64'd1);
    n_settings++;
    for (k = 0; k < 4; k++) push_tick(1'b1, rand48());
    wait_drained();

    // sync at the widest period, with a stopped transport on an exact beat
    write_reg(REG_SYNC, 64'd1);
    write_reg(REG_PERIOD, 64'hFFFF_FFFF);
    write_reg(REG_BAR_COUNT, 64'd8);
    write_reg(REG_BEATS, 64'h0504_0302_0100_FF00);
    write_reg(REG_AMP_OTHER, 64'hFFFF);
    write_reg(REG_AMP_FIRST, 64'd0);
    n_settings++;
    push_tick(1'b1, 48'd0);
    push_tick(1'b1, 48'hFFFF_FFFF_FFFF);
    push_tick(1'b0, 48'h4_FFFF_FFFB);
    push_tick(1'b1, 48'h4_FFFF_FFFB);
    push_tick(1'b1, 48'h5_FFFF_FFFA);
    wait_drained();

    // bypass keeps the position outputs but silences the click
    write_reg(REG_PERIOD, 64'd3);
    write_reg(REG_BYPASS, 64'd1);
    n_settings++;
    for (k = 6; k < 10; k++) push_tick(1'b1, 48'(k));
    push_tick(1'b0, 48'd12);
    wait_drained();
    write_reg(REG_BYPASS, 64'd0);

    // random settings, each with a run of mostly consecutive sample times
    for (ph = 0; ph < 10; ph++) begin
      shuffle_settings();
      t = ($urandom_range(0, 3) == 0) ? rand48() : 48'($urandom_range(0, 5000));
      for (k = 0; k < 40; k++) begin
        t = ($urandom_range(0, 9) == 0) ? rand48() : t + 48'd1;
        push_tick($urandom_range(0, 7) != 0, t);
      end
      wait_drained();
    end

    repeat (60) @(negedge clk);
    if (click_q.size() != 0)
      flag_mismatch("results never delivered", '0, 64'(click_q.size()));
    $display("%0d sample ticks under %0d register settings, free-run and sync, bypass on and off",
             n_sent, n_settings);
    $display("%0d click items checked, %0d of them on a beat", n_checked, n_beats);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
